// ----- rtl/sdcd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdcd_pkg
// Shared types, calendar constants and reciprocal factors for the serial day
// to calendar date converter.
// ----------------------------------------------------------------------------
package sdcd_pkg;

  // input beat: signed day count and millisecond magnitude
  typedef struct packed {
    logic signed [22:0] day_count;
    logic [26:0]        ms_of_day;
  } sdcd_in_t;

  // result beat
  typedef struct packed {
    logic        valid_res;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  millisecond;
    logic [2:0]  weekday;
  } sdcd_out_t;

  // date path status and fields toward the output stage
  typedef struct packed {
    logic        vld;
    logic        ok;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  mday;
    logic [2:0]  weekday;
  } sdcd_date_t;

  // time of day fields
  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [9:0] millisecond;
  } sdcd_tod_t;

  localparam logic signed [22:0] MIN_DAY      = -23'sd657434;
  localparam logic signed [22:0] MAX_DAY      = 23'sd2958465;
  localparam logic signed [23:0] EPOCH_OFFSET = 24'sd693959;
  // day 0 is a saturday; offset keeps the weekday argument non-negative
  localparam logic signed [23:0] WDAY_OFFSET  = 24'sd657446;

  localparam logic [26:0] DAY_MS     = 27'd86400000;
  localparam logic [17:0] DAYS_400Y  = 18'd146097;
  localparam logic [15:0] DAYS_100Y  = 16'd36524;
  localparam logic [10:0] DAYS_4Y    = 11'd1461;
  localparam logic [8:0]  DAYS_1Y    = 9'd365;
  localparam logic [9:0]  MS_PER_SEC = 10'd1000;
  localparam logic [5:0]  SIXTY      = 6'd60;

  // floor(2^sh / d): the estimate is the quotient or one below it
  localparam int          RECIP_400Y_SH = 32;
  localparam logic [14:0] RECIP_400Y    = 15'((64'd1 << RECIP_400Y_SH) / 64'd146097);
  localparam int          RECIP_4Y_SH   = 24;
  localparam logic [13:0] RECIP_4Y      = 14'((64'd1 << RECIP_4Y_SH) / 64'd1461);
  localparam int          RECIP_MS_SH   = 32;
  localparam logic [22:0] RECIP_MS      = 23'((64'd1 << RECIP_MS_SH) / 64'd1000);
  localparam int          RECIP_60_SH   = 24;
  localparam logic [18:0] RECIP_60      = 19'((64'd1 << RECIP_60_SH) / 64'd60);

  // days in the first m months of a common year
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] d;
    unique case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      4'd12:   d = 9'd365;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ----- rtl/sdcd_date.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdcd_date
// Nine-stage date pipeline: window check, 400/100/4/1-year split, month and
// day lookup, weekday by residue of the day count.
// ----------------------------------------------------------------------------
module sdcd_date (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  sdcd_pkg::sdcd_in_t  in_beat,
  output sdcd_pkg::sdcd_date_t out_date
);

  localparam logic [17:0] CENT1 = 18'(sdcd_pkg::DAYS_100Y) + 18'd1;
  localparam logic [17:0] CENT2 = 18'(sdcd_pkg::DAYS_100Y) * 18'd2 + 18'd1;
  localparam logic [17:0] CENT3 = 18'(sdcd_pkg::DAYS_100Y) * 18'd3 + 18'd1;
  localparam logic [10:0] YR1   = 11'(sdcd_pkg::DAYS_1Y);
  localparam logic [10:0] YR2   = 11'(sdcd_pkg::DAYS_1Y) * 11'd2;
  localparam logic [10:0] YR3   = 11'(sdcd_pkg::DAYS_1Y) * 11'd3;

  logic [8:0] vld_r;
  logic [8:0] ok_r;

  // stage 1: window, absolute day, weekday argument
  logic signed [22:0] day_s;
  logic signed [23:0] day_x, abs_x, wk_x;
  logic               in_win, on_limit, ms_zero, ok1_nxt;
  logic [21:0]        abs1_r, wk1_r;

  assign day_s    = in_beat.day_count;
  assign day_x    = {day_s[22], day_s};
  assign abs_x    = day_x + sdcd_pkg::EPOCH_OFFSET;
  assign wk_x     = day_x + sdcd_pkg::WDAY_OFFSET;
  assign in_win   = (day_s >= sdcd_pkg::MIN_DAY) && (day_s <= sdcd_pkg::MAX_DAY);
  assign on_limit = (day_s == sdcd_pkg::MIN_DAY) || (day_s == sdcd_pkg::MAX_DAY);
  assign ms_zero  = (in_beat.ms_of_day == '0) || (in_beat.ms_of_day == sdcd_pkg::DAY_MS);
  assign ok1_nxt  = in_win && !(on_limit && !ms_zero);

  // stage 2: 400-year quotient estimate, weekday fold (8 = 1 mod 7)
  logic [36:0] q400_prod;
  logic [4:0]  q400e_nxt;
  logic [5:0]  ws_nxt;
  logic [21:0] abs2_r;
  logic [4:0]  q400e2_r;
  logic [5:0]  ws2_r;

  assign q400_prod = 37'(abs1_r) * 37'(sdcd_pkg::RECIP_400Y);
  assign q400e_nxt = q400_prod[sdcd_pkg::RECIP_400Y_SH +: 5];

  always_comb begin
    ws_nxt = 6'(wk1_r[21]);
    for (int g = 0; g < 7; g++) begin
      ws_nxt = ws_nxt + 6'(wk1_r[3*g +: 3]);
    end
  end

  // stage 3: 400-year correction, weekday finish
  logic [21:0] r400_w;
  logic        r400_ge;
  logic [4:0]  q400_nxt;
  logic [17:0] r400_nxt;
  logic [3:0]  wsum;
  logic [2:0]  wd_nxt;
  logic [4:0]  q400_3_r;
  logic [17:0] r400_3_r;
  logic [2:0]  wd3_r;

  assign r400_w   = abs2_r - 22'(q400e2_r) * 22'(sdcd_pkg::DAYS_400Y);
  assign r400_ge  = r400_w >= 22'(sdcd_pkg::DAYS_400Y);
  assign q400_nxt = q400e2_r + 5'(r400_ge);
  assign r400_nxt = r400_ge ? 18'(r400_w - 22'(sdcd_pkg::DAYS_400Y)) : 18'(r400_w);
  assign wsum     = {1'b0, ws2_r[2:0]} + {1'b0, ws2_r[5:3]};

  always_comb begin
    if (wsum >= 4'd14) begin
      wd_nxt = 3'(wsum - 4'd14);
    end else if (wsum >= 4'd7) begin
      wd_nxt = 3'(wsum - 4'd7);
    end else begin
      wd_nxt = 3'(wsum);
    end
  end

  // stage 4: century within the 400-year block
  logic [1:0]  cent_nxt;
  logic [15:0] b_nxt;
  logic [4:0]  q400_4_r;
  logic [1:0]  cent4_r;
  logic [15:0] b4_r;
  logic [2:0]  wd4_r;

  assign cent_nxt = 2'(r400_3_r >= CENT1) + 2'(r400_3_r >= CENT2) + 2'(r400_3_r >= CENT3);
  assign b_nxt    = 16'(r400_3_r - 18'(cent_nxt) * 18'(sdcd_pkg::DAYS_100Y));

  // stage 5: 4-year quotient estimate
  logic [29:0] q4_prod;
  logic [4:0]  q4e_nxt;
  logic [4:0]  q400_5_r;
  logic [1:0]  cent5_r;
  logic [15:0] b5_r;
  logic [4:0]  q4e5_r;
  logic [2:0]  wd5_r;

  assign q4_prod = 30'(b4_r) * 30'(sdcd_pkg::RECIP_4Y);
  assign q4e_nxt = q4_prod[sdcd_pkg::RECIP_4Y_SH +: 5];

  // stage 6: 4-year correction
  logic [15:0] r4_w;
  logic        r4_ge;
  logic [4:0]  q4_nxt;
  logic [10:0] rem4_nxt;
  logic [4:0]  q400_6_r;
  logic [1:0]  cent6_r;
  logic [4:0]  q4_6_r;
  logic [10:0] rem4_6_r;
  logic [2:0]  wd6_r;

  assign r4_w     = b5_r - 16'(q4e5_r) * 16'(sdcd_pkg::DAYS_4Y);
  assign r4_ge    = r4_w >= 16'(sdcd_pkg::DAYS_4Y);
  assign q4_nxt   = q4e5_r + 5'(r4_ge);
  assign rem4_nxt = r4_ge ? 11'(r4_w - 16'(sdcd_pkg::DAYS_4Y)) : 11'(r4_w);

  // stage 7: year within the 4-year block
  // the first 4-year block of a non-leap century starts with a common year
  logic        leap4_nxt;
  logic [10:0] day4;
  logic [1:0]  yr4_nxt;
  logic [8:0]  dayp_nxt;
  logic [4:0]  q400_7_r;
  logic [1:0]  cent7_r;
  logic [4:0]  q4_7_r;
  logic [1:0]  yr4_7_r;
  logic        leap4_7_r;
  logic [8:0]  dayp7_r;
  logic [2:0]  wd7_r;

  assign leap4_nxt = !((cent6_r != 2'd0) && (q4_6_r == 5'd0));
  assign day4      = rem4_6_r - 11'(!leap4_nxt);
  assign yr4_nxt   = 2'(day4 >= YR1 + 11'(leap4_nxt)) + 2'(day4 >= YR2 + 11'(leap4_nxt))
                   + 2'(day4 >= YR3 + 11'(leap4_nxt));
  assign dayp_nxt  = 9'(day4 - 11'(yr4_nxt) * 11'(sdcd_pkg::DAYS_1Y)
                   - 11'((yr4_nxt != 2'd0) && leap4_nxt));

  // stage 8: year sum, feb 29 case, month search
  logic        is_leap;
  logic        feb29_nxt;
  logic [13:0] year_nxt;
  logic [8:0]  dd_nxt;
  logic [3:0]  month_nxt;
  logic [13:0] year8_r;
  logic        feb29_8_r;
  logic [8:0]  dd8_r;
  logic [3:0]  month8_r;
  logic [2:0]  wd8_r;

  assign is_leap   = (yr4_7_r == 2'd0) && leap4_7_r;
  assign feb29_nxt = is_leap && (dayp7_r == 9'd59);
  assign year_nxt  = 14'(q400_7_r) * 14'd400 + 14'(cent7_r) * 14'd100
                   + 14'(q4_7_r) * 14'd4 + 14'(yr4_7_r);
  assign dd_nxt    = dayp7_r - 9'(is_leap && (dayp7_r >= 9'd60)) + 9'd1;

  always_comb begin
    month_nxt = 4'd1;
    for (int k = 1; k < 12; k++) begin
      month_nxt = month_nxt + 4'(dd_nxt > sdcd_pkg::cum_days(4'(k)));
    end
  end

  // stage 9: day of month
  logic [4:0]  mday_nxt;
  logic [3:0]  mon_nxt;
  logic [13:0] year9_r;
  logic [3:0]  month9_r;
  logic [4:0]  mday9_r;
  logic [2:0]  wd9_r;

  assign mday_nxt = feb29_8_r ? 5'd29 : 5'(dd8_r - sdcd_pkg::cum_days(month8_r - 4'd1));
  assign mon_nxt  = feb29_8_r ? 4'd2 : month8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[7:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    ok_r      <= {ok_r[7:0], ok1_nxt};
    abs1_r    <= abs_x[21:0];
    wk1_r     <= wk_x[21:0];
    abs2_r    <= abs1_r;
    q400e2_r  <= q400e_nxt;
    ws2_r     <= ws_nxt;
    q400_3_r  <= q400_nxt;
    r400_3_r  <= r400_nxt;
    wd3_r     <= wd_nxt;
    q400_4_r  <= q400_3_r;
    cent4_r   <= cent_nxt;
    b4_r      <= b_nxt;
    wd4_r     <= wd3_r;
    q400_5_r  <= q400_4_r;
    cent5_r   <= cent4_r;
    b5_r      <= b4_r;
    q4e5_r    <= q4e_nxt;
    wd5_r     <= wd4_r;
    q400_6_r  <= q400_5_r;
    cent6_r   <= cent5_r;
    q4_6_r    <= q4_nxt;
    rem4_6_r  <= rem4_nxt;
    wd6_r     <= wd5_r;
    q400_7_r  <= q400_6_r;
    cent7_r   <= cent6_r;
    q4_7_r    <= q4_6_r;
    yr4_7_r   <= yr4_nxt;
    leap4_7_r <= leap4_nxt;
    dayp7_r   <= dayp_nxt;
    wd7_r     <= wd6_r;
    year8_r   <= year_nxt;
    feb29_8_r <= feb29_nxt;
    dd8_r     <= dd_nxt;
    month8_r  <= month_nxt;
    wd8_r     <= wd7_r;
    year9_r   <= year8_r;
    month9_r  <= mon_nxt;
    mday9_r   <= mday_nxt;
    wd9_r     <= wd8_r;
  end

  assign out_date.vld     = vld_r[8];
  assign out_date.ok      = ok_r[8];
  assign out_date.year    = year9_r;
  assign out_date.month   = month9_r;
  assign out_date.mday    = mday9_r;
  assign out_date.weekday = wd9_r;

endmodule

// ----- rtl/sdcd_time.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdcd_time
// Nine-stage time-of-day pipeline: day wrap, then divide by 1000, 60 and 60,
// each as a reciprocal multiply stage followed by a correction stage.
// ----------------------------------------------------------------------------
module sdcd_time (
  input  logic                 clk,
  input  logic [26:0]          in_ms,
  output sdcd_pkg::sdcd_tod_t  out_tod
);

  // stage 1: wrap into one day
  logic [26:0] msr_nxt;
  logic [26:0] msr1_r;

  assign msr_nxt = (in_ms >= sdcd_pkg::DAY_MS) ? in_ms - sdcd_pkg::DAY_MS : in_ms;

  // stage 2: seconds estimate
  logic [49:0] sec_prod;
  logic [16:0] sece_nxt;
  logic [26:0] msr2_r;
  logic [16:0] sece2_r;

  assign sec_prod = 50'(msr1_r) * 50'(sdcd_pkg::RECIP_MS);
  assign sece_nxt = sec_prod[sdcd_pkg::RECIP_MS_SH +: 17];

  // stage 3: seconds correction
  logic [26:0] rms_w;
  logic        rms_ge;
  logic [16:0] sec_nxt;
  logic [9:0]  msec_nxt;
  logic [16:0] sec3_r;
  logic [9:0]  msec3_r;

  assign rms_w    = msr2_r - 27'(sece2_r) * 27'(sdcd_pkg::MS_PER_SEC);
  assign rms_ge   = rms_w >= 27'(sdcd_pkg::MS_PER_SEC);
  assign sec_nxt  = sece2_r + 17'(rms_ge);
  assign msec_nxt = rms_ge ? 10'(rms_w - 27'(sdcd_pkg::MS_PER_SEC)) : 10'(rms_w);

  // stage 4: minutes estimate
  logic [35:0] min_prod;
  logic [10:0] mine_nxt;
  logic [16:0] sec4_r;
  logic [10:0] mine4_r;
  logic [9:0]  msec4_r;

  assign min_prod = 36'(sec3_r) * 36'(sdcd_pkg::RECIP_60);
  assign mine_nxt = min_prod[sdcd_pkg::RECIP_60_SH +: 11];

  // stage 5: minutes correction
  logic [16:0] rsec_w;
  logic        rsec_ge;
  logic [10:0] min_nxt;
  logic [5:0]  second_nxt;
  logic [10:0] min5_r;
  logic [5:0]  second5_r;
  logic [9:0]  msec5_r;

  assign rsec_w     = sec4_r - 17'(mine4_r) * 17'(sdcd_pkg::SIXTY);
  assign rsec_ge    = rsec_w >= 17'(sdcd_pkg::SIXTY);
  assign min_nxt    = mine4_r + 11'(rsec_ge);
  assign second_nxt = rsec_ge ? 6'(rsec_w - 17'(sdcd_pkg::SIXTY)) : 6'(rsec_w);

  // stage 6: hours estimate
  logic [29:0] hr_prod;
  logic [4:0]  hre_nxt;
  logic [10:0] min6_r;
  logic [4:0]  hre6_r;
  logic [5:0]  second6_r;
  logic [9:0]  msec6_r;

  assign hr_prod = 30'(min5_r) * 30'(sdcd_pkg::RECIP_60);
  assign hre_nxt = hr_prod[sdcd_pkg::RECIP_60_SH +: 5];

  // stage 7: hours correction
  logic [10:0]         rmin_w;
  logic                rmin_ge;
  sdcd_pkg::sdcd_tod_t tod_nxt;
  sdcd_pkg::sdcd_tod_t tod7_r, tod8_r, tod9_r;

  assign rmin_w              = min6_r - 11'(hre6_r) * 11'(sdcd_pkg::SIXTY);
  assign rmin_ge             = rmin_w >= 11'(sdcd_pkg::SIXTY);
  assign tod_nxt.hour        = hre6_r + 5'(rmin_ge);
  assign tod_nxt.minute      = rmin_ge ? 6'(rmin_w - 11'(sdcd_pkg::SIXTY)) : 6'(rmin_w);
  assign tod_nxt.second      = second6_r;
  assign tod_nxt.millisecond = msec6_r;

  // stages 8 and 9 line up with the date pipeline
  always_ff @(posedge clk) begin
    msr1_r    <= msr_nxt;
    msr2_r    <= msr1_r;
    sece2_r   <= sece_nxt;
    sec3_r    <= sec_nxt;
    msec3_r   <= msec_nxt;
    sec4_r    <= sec3_r;
    mine4_r   <= mine_nxt;
    msec4_r   <= msec3_r;
    min5_r    <= min_nxt;
    second5_r <= second_nxt;
    msec5_r   <= msec4_r;
    min6_r    <= min5_r;
    hre6_r    <= hre_nxt;
    second6_r <= second5_r;
    msec6_r   <= msec5_r;
    tod7_r    <= tod_nxt;
    tod8_r    <= tod7_r;
    tod9_r    <= tod8_r;
  end

  assign out_tod = tod9_r;

endmodule

// ----- rtl/serial_day_to_calendar_date_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_day_to_calendar_date_top
// Serial day count plus millisecond of day to calendar date, time of day and
// weekday, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one beat per clock: busy is high only during reset and clears at the
// clock edge that first samples rst_n high, so start may be held high back
// to back. Every accepted beat gives exactly one result, shown for a single
// cycle with out_strobe; there is no back-pressure, so the receiver must take
// each result in that cycle. Each result passes through the nine register
// stages of the date and time pipelines plus the output register; the
// divisions by 400 and 4 years, 1000 and 60 are each a reciprocal multiply
// stage followed by a correction stage. Dates outside the supported window
// come out with valid_res low and all other fields zero.
module serial_day_to_calendar_date_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  sdcd_pkg::sdcd_in_t  in_data,
  output logic                out_strobe,
  output sdcd_pkg::sdcd_out_t out_data
);

  logic                 busy_r;
  logic                 in_vld;
  sdcd_pkg::sdcd_date_t date;
  sdcd_pkg::sdcd_tod_t  tod;
  sdcd_pkg::sdcd_out_t  out_nxt;
  logic                 out_strobe_r;
  sdcd_pkg::sdcd_out_t  out_data_r;

  assign in_vld = start && !busy_r;

  sdcd_date u_date (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_vld),
    .in_beat  (in_data),
    .out_date (date)
  );

  sdcd_time u_time (
    .clk     (clk),
    .in_ms   (in_data.ms_of_day),
    .out_tod (tod)
  );

  // out-of-window dates report all fields as zero
  always_comb begin
    out_nxt = '0;
    if (date.ok) begin
      out_nxt.valid_res    = 1'b1;
      out_nxt.year         = date.year;
      out_nxt.month        = date.month;
      out_nxt.day_of_month = date.mday;
      out_nxt.hour         = tod.hour;
      out_nxt.minute       = tod.minute;
      out_nxt.second       = tod.second;
      out_nxt.millisecond  = tod.millisecond;
      out_nxt.weekday      = date.weekday;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b1;
      out_strobe_r <= 1'b0;
    end else begin
      busy_r       <= 1'b0;
      out_strobe_r <= date.vld;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_nxt;
  end

  assign busy       = busy_r;
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

// ----- rtl/sdcd_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdcd_chk
// Port-level checks for the serial day converter, bound to the top level.
// ----------------------------------------------------------------------------
module sdcd_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input sdcd_pkg::sdcd_in_t  in_data,
  input logic                out_strobe,
  input sdcd_pkg::sdcd_out_t out_data
);

  // busy only covers reset
  a_busy_low: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy high outside reset");

  // one result per accepted beat, fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n, 10) |-> (out_strobe == $past(start && !busy, 10)))
    else $error("result strobe does not match accepted beat");

  // out-of-window result carries only zeros
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_data.valid_res) |->
      (out_data.year == '0 && out_data.month == '0 && out_data.day_of_month == '0 &&
       out_data.hour == '0 && out_data.minute == '0 && out_data.second == '0 &&
       out_data.millisecond == '0 && out_data.weekday == '0))
    else $error("invalid result with nonzero fields");

  // calendar fields stay in range on a valid beat
  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.valid_res) |->
      (out_data.year >= 14'd100 && out_data.year <= 14'd9999 &&
       out_data.month >= 4'd1 && out_data.month <= 4'd12 &&
       out_data.day_of_month >= 5'd1 && out_data.weekday <= 3'd6))
    else $error("date field out of range");

  // time of day fields stay in range
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |->
      (out_data.hour <= 5'd23 && out_data.minute <= 6'd59 &&
       out_data.second <= 6'd59 && out_data.millisecond <= 10'd999))
    else $error("time field out of range");

endmodule

bind serial_day_to_calendar_date_top sdcd_chk u_sdcd_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_data    (in_data),
  .out_strobe (out_strobe),
  .out_data   (out_data)
);

// ----- test/date_convert_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_convert_checker
// Watches the command and result channels of the serial day converter,
// computes the calendar date, time of day and weekday for every accepted
// beat and compares each strobed result with the oldest pending date.
// ----------------------------------------------------------------------------
module date_convert_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  sdcd_pkg::sdcd_in_t  in_data,
  input  logic                out_strobe,
  input  sdcd_pkg::sdcd_out_t out_data,
  output int                  fail_count,
  output int                  pending_cnt,
  output int                  result_cnt,
  output int                  in_window_cnt,
  output int                  leap_day_cnt
);

  localparam int WINDOW_LO    = -657434;
  localparam int WINDOW_HI    = 2958465;
  localparam int DAYS_TO_EPOCH = 693959;
  localparam int MS_PER_DAY   = 86400000;
  localparam int DAYS_PER_400 = 146097;
  localparam int DAYS_PER_100 = 36524;
  localparam int DAYS_PER_4   = 1461;
  localparam int DAYS_PER_1   = 365;
  localparam int REPORT_MAX   = 10;

  sdcd_pkg::sdcd_out_t pending_dates[$];
  int                  mismatch_cnt = 0;

  function automatic int days_before(input int m);
    case (m)
      1:       return 31;
      2:       return 59;
      3:       return 90;
      4:       return 120;
      5:       return 151;
      6:       return 181;
      7:       return 212;
      8:       return 243;
      9:       return 273;
      10:      return 304;
      11:      return 334;
      12:      return 365;
      default: return 0;
    endcase
  endfunction

  function automatic sdcd_pkg::sdcd_out_t convert_serial_day(input sdcd_pkg::sdcd_in_t beat);
    int                  days, ms, absd, q400, cent, q4, day4, yr4, yr, mon, mday;
    int                  a, yy, mm, n;
    bit                  leap4;
    sdcd_pkg::sdcd_out_t r;
    r    = '0;
    days = {{9{beat.day_count[22]}}, beat.day_count};
    ms   = int'({5'd0, beat.ms_of_day}) % MS_PER_DAY;
    if (days > WINDOW_HI || days < WINDOW_LO) return r;
    if ((days == WINDOW_HI || days == WINDOW_LO) && ms != 0) return r;

    absd  = days + DAYS_TO_EPOCH;
    q400  = absd / DAYS_PER_400;
    absd  = absd % DAYS_PER_400;
    cent  = (absd - 1) / DAYS_PER_100;
    leap4 = 1'b1;
    if (cent != 0) begin
      absd = (absd - 1) % DAYS_PER_100;
      q4   = (absd + 1) / DAYS_PER_4;
      if (q4 != 0) begin
        day4 = (absd + 1) % DAYS_PER_4;
      end else begin
        // first four years of a non-400 century have no leap day
        leap4 = 1'b0;
        day4  = absd;
      end
    end else begin
      q4   = absd / DAYS_PER_4;
      day4 = absd % DAYS_PER_4;
    end

    if (leap4) begin
      yr4 = (day4 - 1) / DAYS_PER_1;
      if (yr4 != 0) day4 = (day4 - 1) % DAYS_PER_1;
    end else begin
      yr4  = day4 / DAYS_PER_1;
      day4 = day4 % DAYS_PER_1;
    end

    yr = q400 * 400 + cent * 100 + q4 * 4 + yr4;

    if (yr4 == 0 && leap4 && day4 == 59) begin
      mon  = 2;
      mday = 29;
    end else begin
      if (yr4 == 0 && leap4 && day4 >= 60) day4--;
      day4++;
      mon = (day4 >> 5) + 1;
      while (mon < 12 && day4 > days_before(mon)) mon++;
      mday = day4 - days_before(mon - 1);
    end

    // weekday via julian day number
    a  = (14 - mon) / 12;
    yy = yr + 4800 - a;
    mm = mon + 12 * a - 3;
    n  = mday + (153 * mm + 2) / 5 + 365 * yy + yy / 4 - yy / 100 + yy / 400 - 32045;

    r.valid_res    = 1'b1;
    r.year         = yr[13:0];
    r.month        = mon[3:0];
    r.day_of_month = mday[4:0];
    r.hour         = 5'(ms / 3600000);
    r.minute       = 6'((ms / 60000) % 60);
    r.second       = 6'((ms / 1000) % 60);
    r.millisecond  = 10'(ms % 1000);
    r.weekday      = 3'((n + 1) % 7);
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int want, input int got);
    mismatch_cnt++;
    fail_count++;
    if (mismatch_cnt <= REPORT_MAX)
      $display("%0t: result %0d %s mismatch: expected %0d, got %0d",
               $realtime, result_cnt, field, want, got);
  endtask

  task automatic compare_date(input sdcd_pkg::sdcd_out_t want,
                              input sdcd_pkg::sdcd_out_t got);
    if (got.valid_res !== want.valid_res)
      report_mismatch("valid_res", want.valid_res, got.valid_res);
    if (got.year !== want.year) report_mismatch("year", want.year, got.year);
    if (got.month !== want.month) report_mismatch("month", want.month, got.month);
    if (got.day_of_month !== want.day_of_month)
      report_mismatch("day_of_month", want.day_of_month, got.day_of_month);
    if (got.hour !== want.hour) report_mismatch("hour", want.hour, got.hour);
    if (got.minute !== want.minute) report_mismatch("minute", want.minute, got.minute);
    if (got.second !== want.second) report_mismatch("second", want.second, got.second);
    if (got.millisecond !== want.millisecond)
      report_mismatch("millisecond", want.millisecond, got.millisecond);
    if (got.weekday !== want.weekday)
      report_mismatch("weekday", want.weekday, got.weekday);
  endtask

  always @(posedge clk) begin
    sdcd_pkg::sdcd_out_t want;
    if (rst_n) begin
      if (start && !busy) pending_dates.push_back(convert_serial_day(in_data));
      if (out_strobe) begin
        if (pending_dates.size() == 0) begin
          mismatch_cnt++;
          fail_count++;
          if (mismatch_cnt <= REPORT_MAX)
            $display("%0t: result beat with no pending date: %h", $realtime, out_data);
        end else begin
          want = pending_dates.pop_front();
          compare_date(want, out_data);
          if (want.valid_res) in_window_cnt++;
          if (want.valid_res && want.month == 4'd2 && want.day_of_month == 5'd29)
            leap_day_cnt++;
        end
        result_cnt++;
      end
    end
    pending_cnt <= pending_dates.size();
  end

endmodule

// ----- test/tb_serial_day_to_calendar_date_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_serial_day_to_calendar_date_top
// Drives directed edge dates and random serial days into the converter with
// varying sender idle rates; a checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module tb_serial_day_to_calendar_date_top;

  localparam int WINDOW_LO     = -657434;
  localparam int WINDOW_HI     = 2958465;
  localparam int DAYS_TO_EPOCH = 693959;
  localparam int MS_PER_DAY    = 86400000;
  localparam int MS_FIELD_MAX  = 134217727;
  localparam int BEATS_PER_PHASE = 585;
  localparam int STALL_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 20;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  sdcd_pkg::sdcd_in_t  in_data = '0;
  logic                out_strobe;
  sdcd_pkg::sdcd_out_t out_data;

  int fail_count, pending_cnt, result_cnt, in_window_cnt, leap_day_cnt;
  int quiet_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  serial_day_to_calendar_date_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  date_convert_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_data       (in_data),
    .out_strobe    (out_strobe),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .pending_cnt   (pending_cnt),
    .result_cnt    (result_cnt),
    .in_window_cnt (in_window_cnt),
    .leap_day_cnt  (leap_day_cnt)
  );

  // serial day of 1 jan of year y, proleptic gregorian
  function automatic int year_start(input int y);
    return 365 * y + (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400 + 1 - DAYS_TO_EPOCH;
  endfunction

  function automatic sdcd_pkg::sdcd_in_t beat_of(input int d, input int ms);
    sdcd_pkg::sdcd_in_t b;
    b.day_count = d[22:0];
    b.ms_of_day = ms[26:0];
    return b;
  endfunction

  function automatic int pick_ms();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 0;
    if (r < 15) return MS_PER_DAY - 1;
    if (r < 22) return $urandom_range(MS_FIELD_MAX, MS_PER_DAY);
    return $urandom_range(MS_PER_DAY - 1, 0);
  endfunction

  function automatic sdcd_pkg::sdcd_in_t random_beat();
    int          r, y, d;
    int unsigned w;
    r = $urandom_range(99);
    if (r < 10) begin
      // raw field values, mostly outside the window
      w = $urandom;
      d = int'(w[22:0]);
      w = $urandom;
      return beat_of(d, int'(w[26:0]));
    end
    if (r < 22) begin
      d = ($urandom_range(1) != 0) ? WINDOW_LO : WINDOW_HI;
      d = d + $urandom_range(4) - 2;
      return beat_of(d, pick_ms());
    end
    if (r < 45) begin
      y = ($urandom_range(1) != 0) ? $urandom_range(99, 1) * 100 : $urandom_range(9999, 100);
      if ($urandom_range(1) != 0)
        d = year_start(y) + 57 + $urandom_range(3);   // feb 27 to mar 1 or 2
      else
        d = year_start(y) - 1 + $urandom_range(1);    // dec 31 / jan 1
      return beat_of(d, pick_ms());
    end
    d = $urandom_range(WINDOW_HI - WINDOW_LO, 0) + WINDOW_LO;
    return beat_of(d, pick_ms());
  endfunction

  task automatic send_beat(input sdcd_pkg::sdcd_in_t b);
    start   <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_gap(input int pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // watchdog: nothing moving on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int idle_pct[3];
    idle_pct = '{0, 77, 11};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // edges of the window, field extremes, leap days and ms wrap
    send_beat(beat_of(0, 0));
    send_beat(beat_of(WINDOW_LO, 0));
    send_beat(beat_of(WINDOW_LO, 1));
    send_beat(beat_of(WINDOW_LO - 1, 0));
    send_beat(beat_of(WINDOW_HI, 0));
    send_beat(beat_of(WINDOW_HI, 1));
    send_beat(beat_of(WINDOW_HI + 1, 0));
    send_beat(beat_of(-2097152, 0));
    send_beat(beat_of(4194303, MS_FIELD_MAX));
    send_beat(beat_of(WINDOW_HI, MS_PER_DAY));
    send_beat(beat_of(WINDOW_LO, MS_PER_DAY));
    send_beat(beat_of(0, MS_PER_DAY - 1));
    send_beat(beat_of(-1, 43200000));
    send_beat(beat_of(year_start(2000) + 59, 0));
    send_beat(beat_of(year_start(1900) + 58, 3599999));
    send_beat(beat_of(year_start(1900) + 59, 3600000));
    send_beat(beat_of(year_start(2100) + 58, 59999));
    send_beat(beat_of(year_start(1600) + 59, 60000));
    send_beat(beat_of(year_start(400) + 59, 12345678));
    send_beat(beat_of(year_start(2025) - 1, 999));
    send_beat(beat_of(WINDOW_LO + 58, 1000));
    send_beat(beat_of(1, MS_FIELD_MAX));
    send_beat(beat_of(-2097152, MS_PER_DAY - 1));

    foreach (idle_pct[p]) begin
      for (int i = 0; i < BEATS_PER_PHASE; i++) begin
        idle_gap(idle_pct[p]);
        send_beat(random_beat());
      end
    end
    start <= 1'b0;

    while (pending_cnt != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("converted %0d beats: %0d in window, %0d out of window, %0d on feb 29",
             result_cnt, in_window_cnt, result_cnt - in_window_cnt, leap_day_cnt);
    $display("random beats sent with sender idle 0, 77 and 11 percent of cycles");
    if (fail_count == 0 && pending_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d failures, %0d results missing", fail_count, pending_cnt);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
